FILE: src/atids_pkg.sv
// ----------------------------------------------------------------------------
// atids_pkg: shared types and constants for the array table
// Command codes, status codes, sequencer states and beat structs.
// ----------------------------------------------------------------------------
`default_nettype none

package atids_pkg;

  localparam int Depth     = 32;
  localparam int DataWidth = 32;
  localparam int AddrW     = $clog2(Depth);
  localparam int CntW      = $clog2(Depth + 1);

  localparam logic [2:0] FUNC_APPEND = 3'd0;
  localparam logic [2:0] FUNC_INSERT = 3'd1;
  localparam logic [2:0] FUNC_DELETE = 3'd2;
  localparam logic [2:0] FUNC_LSRCH  = 3'd3;
  localparam logic [2:0] FUNC_BSRCH  = 3'd4;
  localparam logic [2:0] FUNC_CLEAR  = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_MISS  = 2'd3;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] value;
    logic [5:0]         position;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [4:0]         found_index;
    logic signed [31:0] removed_value;
    logic [5:0]         count;
  } out_beat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_DEL_RD,
    S_DEL_WR,
    S_LS_RD,
    S_LS_CHK,
    S_LS_SWAP,
    S_BS_RD,
    S_BS_CHK,
    S_DONE
  } seq_state_t;

endpackage

`default_nettype wire

FILE: src/atids_ram.sv
// ----------------------------------------------------------------------------
// atids_ram: generic single-port RAM
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module atids_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output      logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

FILE: src/array_table_insert_delete_search.sv
// ----------------------------------------------------------------------------
// array_table_insert_delete_search: dense array table with search
// Sequencer around one single-port element RAM, with a result register.
// ----------------------------------------------------------------------------
// Usage: in_valid/in_ready take one command beat (func, value, position);
//   out_valid/out_ready return one result beat per command; cfg_valid/
//   cfg_ready write the capacity register; do so only while no command is in
//   flight, as the block itself does not enforce it.
// Each entry moved or probed takes a RAM read state and then a write or
//   compare state (INS_RD/INS_WR, DEL_RD/DEL_WR, LS_RD/LS_CHK, BS_RD/BS_CHK),
//   as the single RAM port serves one address at a time; a linear hit past
//   index 0 adds LS_SWAP. Append only writes (INS_WR); errors, clear and
//   unused codes go straight to DONE.
// One command runs at a time; in_ready is high only while the sequencer is
//   idle and out of reset. A finished result moves to the output register,
//   so the next command starts while it waits; if that register is still
//   full the sequencer holds its result and in_ready stays low.
// Reset empties the table (count 0) and sets capacity to 32; the RAM is not
//   cleared, entries past the count never reach a result.
// ----------------------------------------------------------------------------
`default_nettype none

module array_table_insert_delete_search (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire atids_pkg::in_beat_t  in_data,
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  output      atids_pkg::out_beat_t out_data,
  input  wire logic                 cfg_valid,
  output      logic                 cfg_ready,
  input  wire logic [5:0]           cfg_data
);
  import atids_pkg::*;

  seq_state_t state_r, state_nxt;
  logic [5:0]            cap_r;
  logic [CntW-1:0]       cnt_r, cnt_nxt;
  logic [2:0]            func_r, func_nxt;
  logic [DataWidth-1:0]  val_r, val_nxt;
  logic [CntW-1:0]       pos_r, pos_nxt;
  logic [CntW-1:0]       idx_r, idx_nxt;
  logic signed [CntW:0]  lo_r, lo_nxt, hi_r, hi_nxt;
  out_beat_t             res_r, res_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_beat_t             out_r, out_nxt;

  logic                  we;
  logic [AddrW-1:0]      addr;
  logic [DataWidth-1:0]  wdata, rdata;

  logic [CntW-1:0] cap_lim;
  logic signed [CntW:0] mid, mid_dn, mid_up;
  logic [DataWidth-1:0] in_val;
  logic                 del_last;

  atids_ram #(.Width(DataWidth), .Depth(Depth)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  assign cap_lim  = (cap_r > 6'(Depth)) ? CntW'(Depth) : CntW'(cap_r);
  assign mid      = (lo_r + hi_r) >>> 1;
  assign mid_dn   = mid - (CntW+1)'(1);
  assign mid_up   = mid + (CntW+1)'(1);
  assign in_val   = DataWidth'(signed'(in_data.value));
  assign in_ready = rst_n && (state_r == S_IDLE);
  assign cfg_ready = rst_n;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  // the removed element is captured on the first pass, shifts follow
  assign del_last = (lo_r == '0) ? (idx_r + 1'b1 >= cnt_r) : (idx_r + 2'd2 >= cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= 6'd32;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        cap_r <= cfg_data;
      end
    end
    func_r <= func_nxt;
    val_r  <= val_nxt;
    pos_r  <= pos_nxt;
    idx_r  <= idx_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_data.func)
            FUNC_APPEND, FUNC_INSERT: begin
              if (cnt_r >= cap_lim) begin
                state_nxt = S_DONE;
              end else if (in_data.func == FUNC_INSERT && in_data.position > cnt_r) begin
                state_nxt = S_DONE;
              end else if (in_data.func == FUNC_INSERT && in_data.position != cnt_r) begin
                state_nxt = S_INS_RD;
              end else begin
                state_nxt = S_INS_WR;
              end
            end
            FUNC_DELETE: state_nxt = (in_data.position >= cnt_r) ? S_DONE : S_DEL_RD;
            FUNC_LSRCH:  state_nxt = (cnt_r == '0) ? S_DONE : S_LS_RD;
            FUNC_BSRCH:  state_nxt = (cnt_r == '0) ? S_DONE : S_BS_RD;
            default:     state_nxt = S_DONE;
          endcase
        end
      end
      S_INS_RD:  state_nxt = S_INS_WR;
      S_INS_WR:  state_nxt = (idx_r == pos_r) ? S_DONE : S_INS_RD;
      S_DEL_RD:  state_nxt = S_DEL_WR;
      S_DEL_WR:  state_nxt = del_last ? S_DONE : S_DEL_RD;
      S_LS_RD:   state_nxt = S_LS_CHK;
      S_LS_CHK: begin
        if (rdata == val_r) begin
          state_nxt = (idx_r == '0) ? S_DONE : S_LS_SWAP;
        end else if (idx_r + 1'b1 >= cnt_r) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_LS_RD;
        end
      end
      S_LS_SWAP: state_nxt = S_DONE;
      S_BS_RD:   state_nxt = S_BS_CHK;
      S_BS_CHK: begin
        if (rdata == val_r) begin
          state_nxt = S_DONE;
        end else if ((signed'(val_r) < signed'(rdata)) ? (mid_dn < lo_r)
                                                       : (mid_up > hi_r)) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_BS_RD;
        end
      end
      S_DONE:    state_nxt = (!out_valid_r || out_ready) ? S_IDLE : S_DONE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    cnt_nxt  = cnt_r;
    func_nxt = func_r;
    val_nxt  = val_r;
    pos_nxt  = pos_r;
    idx_nxt  = idx_r;
    lo_nxt   = lo_r;
    hi_nxt   = hi_r;
    res_nxt  = res_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_nxt  = out_r;
    we       = 1'b0;
    addr     = idx_r[AddrW-1:0];
    wdata    = val_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt = in_data.func;
          val_nxt  = in_val;
          pos_nxt  = (in_data.func == FUNC_APPEND) ? cnt_r : CntW'(in_data.position);
          res_nxt  = '{status: ST_OK, found_index: '0, removed_value: '0,
                       count: 6'(cnt_r)};
          lo_nxt   = '0;
          hi_nxt   = signed'({1'b0, cnt_r}) - (CntW+1)'(1);
          case (in_data.func)
            FUNC_APPEND, FUNC_INSERT: begin
              if (cnt_r >= cap_lim) begin
                res_nxt.status = ST_FULL;
              end else if (in_data.func == FUNC_INSERT && in_data.position > cnt_r) begin
                res_nxt.status = ST_RANGE;
              end
              idx_nxt = cnt_r;
            end
            FUNC_DELETE: begin
              if (in_data.position >= cnt_r) begin
                res_nxt.status = ST_RANGE;
              end
              idx_nxt = CntW'(in_data.position);
            end
            FUNC_LSRCH, FUNC_BSRCH: begin
              if (cnt_r == '0) begin
                res_nxt.status = ST_MISS;
              end
              idx_nxt = '0;
            end
            FUNC_CLEAR: begin
              cnt_nxt = '0;
              res_nxt.count = '0;
            end
            default: ;
          endcase
        end
      end
      S_INS_RD: begin
        addr = AddrW'(idx_r - 1'b1);
      end
      S_INS_WR: begin
        we = 1'b1;
        if (idx_r == pos_r) begin
          wdata = val_r;
          cnt_nxt = cnt_r + 1'b1;
          res_nxt.count = 6'(cnt_r + 1'b1);
        end else begin
          wdata = rdata;
          idx_nxt = idx_r - 1'b1;
        end
      end
      S_DEL_RD: begin
        addr = AddrW'(idx_r + 1'b1);
        if (lo_r == '0 && idx_r == pos_r) begin
          addr = idx_r[AddrW-1:0];
        end
      end
      S_DEL_WR: begin
        // first pass reads the removed element, later passes shift down
        if (lo_r == '0 && idx_r == pos_r) begin
          res_nxt.removed_value = rdata;
          lo_nxt = (CntW+1)'(1);
          idx_nxt = idx_r;
        end else begin
          we = 1'b1;
          wdata = rdata;
          idx_nxt = idx_r + 1'b1;
        end
        if (del_last) begin
          cnt_nxt = cnt_r - 1'b1;
          res_nxt.count = 6'(cnt_r - 1'b1);
        end
      end
      S_LS_RD: begin
        addr = idx_r[AddrW-1:0];
      end
      S_LS_CHK: begin
        addr = AddrW'(idx_r - 1'b1);
        if (rdata == val_r) begin
          res_nxt.found_index = idx_r[AddrW-1:0];
          if (idx_r != '0) begin
            we = 1'b1;
            wdata = rdata;
          end
        end else if (idx_r + 1'b1 >= cnt_r) begin
          res_nxt.status = ST_MISS;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_LS_SWAP: begin
        // predecessor was read during the check: move it into the hit's slot
        we = 1'b1;
        addr = idx_r[AddrW-1:0];
        wdata = rdata;
      end
      S_BS_RD: begin
        addr = mid[AddrW-1:0];
      end
      S_BS_CHK: begin
        if (rdata == val_r) begin
          res_nxt.found_index = mid[AddrW-1:0];
        end else if (signed'(val_r) < signed'(rdata)) begin
          hi_nxt = mid_dn;
          if (mid_dn < lo_r) res_nxt.status = ST_MISS;
        end else begin
          lo_nxt = mid_up;
          if (mid_up > hi_r) res_nxt.status = ST_MISS;
        end
      end
      S_DONE: begin
        // hand the result to the output register once it is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_nxt = res_r;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: tb/sv/array_table_insert_delete_search_test.sv
// ----------------------------------------------------------------------------
// array_table_insert_delete_search_test: self-checking bench for the table
// Drives command beats with random gaps, predicts every result beat from a
// local copy of the table, and compares each result field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module array_table_insert_delete_search_test;
  timeunit 1ns;
  timeprecision 1ps;
  import atids_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [5:0] cfg_data = '0;

  array_table_insert_delete_search i_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data,
    .cfg_valid, .cfg_ready, .cfg_data
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // local copy of the table
  logic signed [31:0] table_mem [Depth];
  int unsigned        table_cnt;
  int unsigned        cap_reg;
  out_beat_t          pending_results [$];
  int                 errors;
  int                 sent;
  int                 checked;
  bit                 hold_rx;
  int                 func_seen [8];

  function automatic out_beat_t predict_result(in_beat_t cmd);
    out_beat_t r;
    int unsigned lim, pos;
    int lo, hi, mid;
    logic signed [31:0] t;
    r = '0;
    r.status = ST_OK;
    lim = (cap_reg > Depth) ? Depth : cap_reg;
    pos = 32'(cmd.position);
    case (cmd.func)
      FUNC_APPEND, FUNC_INSERT: begin
        if (table_cnt >= lim) r.status = ST_FULL;
        else if (cmd.func == FUNC_INSERT && pos > table_cnt) r.status = ST_RANGE;
        else begin
          if (cmd.func == FUNC_APPEND) pos = table_cnt;
          for (int i = table_cnt; i > pos; i--) table_mem[i] = table_mem[i-1];
          table_mem[pos] = cmd.value;
          table_cnt++;
        end
      end
      FUNC_DELETE: begin
        if (pos >= table_cnt) r.status = ST_RANGE;
        else begin
          r.removed_value = table_mem[pos];
          for (int i = pos; i + 1 < table_cnt; i++) table_mem[i] = table_mem[i+1];
          table_cnt--;
        end
      end
      FUNC_LSRCH: begin
        r.status = ST_MISS;
        for (int i = 0; i < table_cnt; i++) begin
          if (table_mem[i] == cmd.value) begin
            if (i != 0) begin
              t = table_mem[i]; table_mem[i] = table_mem[i-1]; table_mem[i-1] = t;
            end
            r.status = ST_OK;
            r.found_index = 5'(i);
            break;
          end
        end
      end
      FUNC_BSRCH: begin
        lo = 0; hi = int'(table_cnt) - 1;
        r.status = ST_MISS;
        while (lo <= hi) begin
          mid = (lo + hi) / 2;
          if (table_mem[mid] == cmd.value) begin
            r.status = ST_OK; r.found_index = 5'(mid); break;
          end else if (cmd.value < table_mem[mid]) hi = mid - 1;
          else lo = mid + 1;
        end
      end
      FUNC_CLEAR: table_cnt = 0;
      default: ;
    endcase
    r.count = 6'(table_cnt);
    return r;
  endfunction

  // enter at a falling edge; valid stays up after the beat until the next
  // call replaces or drops it, or a drain drops it
  task automatic send_cmd(logic [2:0] f, logic signed [31:0] v, logic [5:0] p);
    in_beat_t c;
    int unsigned gap_n;
    gap_n = $urandom_range(0, 7);
    c.func = f; c.value = v; c.position = p;
    if (gap_n != 0) begin
      in_valid <= 1'b0;
      repeat (gap_n) @(negedge clk);
    end
    in_data  <= c;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_result(c));
    func_seen[f]++;
    sent++;
    @(negedge clk);
  endtask

  // receiver: random wait per beat, long hold-off while hold_rx is set
  initial begin
    int unsigned gap_n;
    @(negedge clk);
    forever begin
      gap_n = $urandom_range(0, 7);
      if (gap_n != 0 || hold_rx) begin
        out_ready <= 1'b0;
        repeat (gap_n) @(negedge clk);
        while (hold_rx) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_valid));
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    out_beat_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        errors++;
      end else begin
        e = pending_results.pop_front();
        checked++;
        if (out_data.status !== e.status)
          $display("%0t: status exp %0d got %0d", $time, e.status, out_data.status);
        if (out_data.found_index !== e.found_index)
          $display("%0t: found_index exp %0d got %0d", $time, e.found_index,
                   out_data.found_index);
        if (out_data.removed_value !== e.removed_value)
          $display("%0t: removed_value exp %0d got %0d", $time, e.removed_value,
                   out_data.removed_value);
        if (out_data.count !== e.count)
          $display("%0t: count exp %0d got %0d", $time, e.count, out_data.count);
        if (out_data !== e) errors++;
      end
    end
  end

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_capacity(logic [5:0] c);
    drain();
    cfg_data  <= c;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cap_reg = 32'(c);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 3))
      0: return $signed($urandom_range(0, 7)) - 4;
      1: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'h7fff_fffc + 31'($urandom_range(0, 3))};
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    send_cmd(FUNC_DELETE, 0, 0);          // delete on empty table
    send_cmd(FUNC_LSRCH, 5, 0);           // search on empty table
    send_cmd(FUNC_BSRCH, 5, 0);
    send_cmd(FUNC_INSERT, 7, 1);          // index beyond count
    send_cmd(FUNC_APPEND, 32'sh8000_0000, 0);
    send_cmd(FUNC_APPEND, -1, 63);
    send_cmd(FUNC_INSERT, 32'sh7fff_ffff, 2); // index equal to count
    send_cmd(FUNC_INSERT, 0, 1);
    send_cmd(FUNC_BSRCH, 0, 0);
    send_cmd(FUNC_BSRCH, 32'sh7fff_ffff, 0);
    send_cmd(FUNC_LSRCH, 32'sh7fff_ffff, 0);
    send_cmd(FUNC_LSRCH, 32'sh8000_0000, 0);
    send_cmd(FUNC_DELETE, 0, 63);
    send_cmd(FUNC_DELETE, 0, 1);
    send_cmd(3'd6, 1, 1);                 // unused codes leave the table unchanged
    send_cmd(3'd7, 1, 1);
    send_cmd(FUNC_CLEAR, 0, 0);
    send_cmd(FUNC_DELETE, 0, 0);
  endtask

  task automatic test_capacity_limits();
    write_capacity(6'd1);
    send_cmd(FUNC_APPEND, 3, 0);
    send_cmd(FUNC_APPEND, 4, 0);          // full
    send_cmd(FUNC_INSERT, 4, 9);          // full wins over range
    write_capacity(6'd0);                 // always full
    send_cmd(FUNC_CLEAR, 0, 0);
    send_cmd(FUNC_APPEND, 1, 0);
    write_capacity(6'd63);                // saturates to depth
    for (int i = 0; i < 34; i++) send_cmd(FUNC_APPEND, i - 16, 0);
    send_cmd(FUNC_BSRCH, 15, 0);
    send_cmd(FUNC_BSRCH, -16, 0);
    send_cmd(FUNC_LSRCH, 15, 0);
    send_cmd(FUNC_DELETE, 0, 0);
    send_cmd(FUNC_DELETE, 0, 30);
  endtask

  task automatic test_backpressure();
    hold_rx = 1'b1;
    fork
      begin
        for (int i = 0; i < 6; i++) send_cmd(FUNC_INSERT, $urandom, 0);
      end
      begin
        repeat (400) @(negedge clk);
        hold_rx = 1'b0;
      end
    join
  endtask

  task automatic test_random(int n, logic [5:0] cap);
    logic [2:0] f;
    logic signed [31:0] v;
    int k;
    write_capacity(cap);
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 30) f = FUNC_APPEND;
      else if (k < 50) f = FUNC_INSERT;
      else if (k < 68) f = FUNC_DELETE;
      else if (k < 83) f = FUNC_LSRCH;
      else if (k < 96) f = FUNC_BSRCH;
      else if (k < 98) f = FUNC_CLEAR;
      else f = 3'($urandom_range(6, 7));
      // search keys mostly come from the table
      if ((f == FUNC_LSRCH || f == FUNC_BSRCH) && table_cnt != 0 && $urandom_range(0, 3) != 0)
        v = table_mem[$urandom_range(0, table_cnt - 1)];
      else v = rand_value();
      send_cmd(f, v, ($urandom_range(0, 9) == 0) ? 6'($urandom) :
               6'($urandom_range(0, table_cnt + 1)));
    end
  endtask

  task automatic test_sorted();
    logic signed [31:0] base;
    drain();
    send_cmd(FUNC_CLEAR, 0, 0);
    base = $urandom;
    base = base >>> 2;
    for (int i = 0; i < 20; i++) begin
      base = base + $urandom_range(1, 1000);
      send_cmd(FUNC_APPEND, base, 0);
    end
    for (int i = 0; i < 30; i++)
      send_cmd(FUNC_BSRCH, ($urandom_range(0, 3) != 0) ?
               table_mem[$urandom_range(0, table_cnt - 1)] : rand_value(), 0);
  endtask

  initial begin
    errors = 0; sent = 0; checked = 0; hold_rx = 1'b0;
    table_cnt = 0; cap_reg = 32;
    foreach (table_mem[i]) table_mem[i] = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_capacity_limits();
    test_backpressure();
    test_random(500, 6'd32);
    test_sorted();
    test_random(350, 6'd7);
    test_sorted();
    test_random(450, 6'd20);
    drain();
    $display("Sent %0d commands (append %0d insert %0d delete %0d lsearch %0d bsearch %0d)",
             sent, func_seen[0], func_seen[1], func_seen[2], func_seen[3], func_seen[4]);
    $display("Checked %0d result beats over capacities 0, 1, 7, 20, 32 and 63", checked);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #8ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
src/atids_pkg.sv
src/atids_ram.sv
src/array_table_insert_delete_search.sv
tb/sv/array_table_insert_delete_search_test.sv
